[rtl/nonuniform_grid_cell_locator_core_assert.svh]
// Assertion macros shared by the locator checker
`ifndef NONUNIFORM_GRID_CELL_LOCATOR_CORE_ASSERT_SVH
`define NONUNIFORM_GRID_CELL_LOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NGCL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NGCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ngcl_pkg.sv]
// Shared constants, types and codes of the nonuniform grid cell locator
package ngcl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int GHOST_CELLS = 2;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int IDX_W   = (ADDR_W > 8) ? ADDR_W : 8;
  localparam int END_W   = IDX_W + 1;
  localparam int COORD_W = 32;
  localparam int CELL_W  = 8;
  localparam int CNT_W   = 8;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 32;

  // Input tdata field offsets
  localparam int IN_AXIS_LSB  = 0;
  localparam int IN_SLOT_LSB  = 2;
  localparam int IN_COORD_LSB = 10;
  localparam int IN_PX_LSB    = 42;
  localparam int IN_PY_LSB    = 74;
  localparam int IN_PZ_LSB    = 106;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOCATE = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] CFG_CELLS_X    = 2'd0;
  localparam logic [1:0] CFG_CELLS_Y    = 2'd1;
  localparam logic [1:0] CFG_CELLS_Z    = 2'd2;
  localparam logic [1:0] CFG_RIGHT_EDGE = 2'd3;

  // Vertex write into one axis table
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [COORD_W-1:0] data;
  } ngcl_wr_t;

  // Locate request to one axis walker
  typedef struct packed {
    logic                      start;
    logic [CNT_W-1:0]          cells;
    logic                      incl_hi;
    logic signed [COORD_W-1:0] coord;
  } ngcl_req_t;

  // Walker status and result
  typedef struct packed {
    logic              busy;
    logic              in_box;
    logic [CELL_W-1:0] cell_idx;
  } ngcl_res_t;

endpackage

[rtl/ngcl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data
module ngcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ngcl_axis_walk.sv]
// One axis: vertex table memory and the linear midpoint walk over it
module ngcl_axis_walk
  import ngcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ngcl_wr_t  wr,
  input  ngcl_req_t req,
  output ngcl_res_t res
);

  typedef enum logic [1:0] {W_IDLE, W_LO, W_WALK, W_HI} walk_state_t;

  localparam logic [ADDR_W-1:0] GHOST_ADDR = ADDR_W'(GHOST_CELLS);
  localparam logic [END_W-1:0]  LAST_SLOT  = END_W'(TABLE_DEPTH - 1);

  walk_state_t               state_r;
  logic signed [COORD_W-1:0] coord_r;
  logic signed [COORD_W-1:0] lo_r;
  logic signed [COORD_W-1:0] prev_r;
  logic [ADDR_W-1:0]         i_r;
  logic [ADDR_W-1:0]         end_r;
  logic                      incl_r;
  logic [CELL_W-1:0]         cell_r;
  logic                      inside_r;

  logic                      ren;
  logic [ADDR_W-1:0]         raddr;
  logic signed [COORD_W-1:0] rdata;
  logic signed [COORD_W:0]   pair_sum;
  logic signed [COORD_W:0]   twice_c;
  logic                      step_ok;
  logic [ADDR_W-1:0]         i_inc;
  logic                      at_end;
  logic [END_W-1:0]          end_sum;
  logic [ADDR_W-1:0]         end_nxt;
  logic                      lo_ok;
  logic                      hi_ok;

  ngcl_ram #(
    .WIDTH (COORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    pair_sum = {prev_r[COORD_W-1], prev_r} + {rdata[COORD_W-1], rdata};
    twice_c  = {coord_r, 1'b0};
    step_ok  = pair_sum < twice_c;
    i_inc    = i_r + ADDR_W'(1);
    at_end   = i_inc >= end_r;
    end_sum  = END_W'(GHOST_CELLS) + END_W'(req.cells);
    end_nxt  = (end_sum > LAST_SLOT) ? ADDR_W'(LAST_SLOT) : ADDR_W'(end_sum);
    lo_ok    = lo_r <= coord_r;
    hi_ok    = incl_r ? (coord_r <= rdata) : (coord_r < rdata);
  end

  // Read address: ghost slot, its neighbor, then one slot ahead per step,
  // and the end slot last for the upper box bound
  always_comb begin
    ren   = 1'b0;
    raddr = GHOST_ADDR;
    case (state_r)
      W_IDLE: begin
        ren   = req.start;
        raddr = GHOST_ADDR;
      end
      W_LO: begin
        ren   = 1'b1;
        raddr = GHOST_ADDR + ADDR_W'(1);
      end
      W_WALK: begin
        ren   = 1'b1;
        raddr = (step_ok && !at_end) ? (i_r + ADDR_W'(2)) : end_r;
      end
      W_HI: begin
        ren = 1'b0;
      end
      default: begin
        ren = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      case (state_r)
        W_IDLE: begin
          if (req.start) begin
            coord_r <= req.coord;
            incl_r  <= req.incl_hi;
            end_r   <= end_nxt;
            i_r     <= GHOST_ADDR;
            state_r <= W_LO;
          end
        end
        W_LO: begin
          lo_r    <= rdata;
          prev_r  <= rdata;
          state_r <= W_WALK;
        end
        W_WALK: begin
          if (step_ok) begin
            i_r <= i_inc;
          end
          if (step_ok && !at_end) begin
            prev_r <= rdata;
          end else begin
            state_r <= W_HI;
          end
        end
        W_HI: begin
          cell_r   <= CELL_W'(IDX_W'(i_r) - IDX_W'(1));
          inside_r <= lo_ok && hi_ok;
          state_r  <= W_IDLE;
        end
        default: begin
          state_r <= W_IDLE;
        end
      endcase
    end
  end

  assign res.busy     = (state_r != W_IDLE);
  assign res.in_box   = inside_r;
  assign res.cell_idx = cell_r;

endmodule

[rtl/nonuniform_grid_cell_locator_core.sv]
// Top level of the nonuniform grid cell locator: ports, registers, control
//
// Keeps one vertex table per axis (signed Q16.16, ghosts included), each in
// its own memory with one read port. A load item (tuser 0) writes one
// vertex; loads to axis 3 or to a slot past the table are dropped. A
// locate item (tuser 1) walks all three axes at once, one vertex read per
// cycle and axis: from the ghost slot it steps while the midpoint of
// neighboring vertices is below the coordinate, up to ghost + cells
// (saturated at the last slot). Each axis makes at least one midpoint
// test, at most cells of them when cells is nonzero, and never more than
// 253. The input stays closed during a walk and while a finished walk
// waits for the output register; it opens again once the result sits in
// that register. cell_* is the step position minus one (wraps to 255
// below zero); in_box flags the point inside [v[ghost], v[end]) on every
// axis, upper bound inclusive on axes set in right_edge_mask. Write
// configuration only while idle. Tables read undefined until loaded.
module nonuniform_grid_cell_locator_core
  import ngcl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: axis, vertex_slot, vertex_coord, point_x, point_y, point_z
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: cell_x, cell_y, cell_z, in_box
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  typedef enum logic {S_IDLE, S_RUN} ctl_state_t;

  ctl_state_t             state_r;
  logic [CNT_W-1:0]       cells_x_r;
  logic [CNT_W-1:0]       cells_y_r;
  logic [CNT_W-1:0]       cells_z_r;
  logic [2:0]             right_edge_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                   in_fire;
  logic                   load_ok;
  logic                   locate_go;
  logic [1:0]             in_axis;
  logic [7:0]             in_slot;
  logic                   walk_busy;
  logic                   out_free;
  logic                   out_load;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  ngcl_wr_t  wr_x, wr_y, wr_z;
  ngcl_req_t req_x, req_y, req_z;
  ngcl_res_t res_x, res_y, res_z;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_axis    = in_tdata[IN_AXIS_LSB +: 2];
  assign in_slot    = in_tdata[IN_SLOT_LSB +: 8];
  assign load_ok    = in_fire && (in_tuser == REQ_LOAD)
                      && ({{END_W{1'b0}}, in_slot} < (END_W + 8)'(TABLE_DEPTH));
  assign locate_go  = in_fire && (in_tuser == REQ_LOCATE);

  // Route a vertex load straight into the selected axis table
  always_comb begin
    wr_x.addr = ADDR_W'(in_slot);
    wr_x.data = in_tdata[IN_COORD_LSB +: COORD_W];
    wr_x.we   = load_ok && (in_axis == AXIS_X);
    wr_y      = wr_x;
    wr_y.we   = load_ok && (in_axis == AXIS_Y);
    wr_z      = wr_x;
    wr_z.we   = load_ok && (in_axis == AXIS_Z);
  end

  // Start all three walks together on a locate
  always_comb begin
    req_x.start   = locate_go;
    req_x.cells   = cells_x_r;
    req_x.incl_hi = right_edge_r[0];
    req_x.coord   = in_tdata[IN_PX_LSB +: COORD_W];
    req_y.start   = locate_go;
    req_y.cells   = cells_y_r;
    req_y.incl_hi = right_edge_r[1];
    req_y.coord   = in_tdata[IN_PY_LSB +: COORD_W];
    req_z.start   = locate_go;
    req_z.cells   = cells_z_r;
    req_z.incl_hi = right_edge_r[2];
    req_z.coord   = in_tdata[IN_PZ_LSB +: COORD_W];
  end

  ngcl_axis_walk u_walk_x (.clk(clk), .rst_n(rst_n), .wr(wr_x), .req(req_x), .res(res_x));
  ngcl_axis_walk u_walk_y (.clk(clk), .rst_n(rst_n), .wr(wr_y), .req(req_y), .res(res_y));
  ngcl_axis_walk u_walk_z (.clk(clk), .rst_n(rst_n), .wr(wr_z), .req(req_z), .res(res_z));

  assign walk_busy    = res_x.busy || res_y.busy || res_z.busy;
  assign out_free     = !out_valid_r || out_tready;
  assign out_load     = (state_r == S_RUN) && !walk_busy && out_free;
  assign out_data_nxt = {7'd0, res_x.in_box && res_y.in_box && res_z.in_box,
                         res_z.cell_idx, res_y.cell_idx, res_x.cell_idx};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r    <= CNT_W'(1);
      cells_y_r    <= CNT_W'(1);
      cells_z_r    <= CNT_W'(1);
      right_edge_r <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CELLS_X:    cells_x_r    <= cfg_wdata;
        CFG_CELLS_Y:    cells_y_r    <= cfg_wdata;
        CFG_CELLS_Z:    cells_z_r    <= cfg_wdata;
        CFG_RIGHT_EDGE: right_edge_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Control: hold the input closed during a walk, then move the result
  // into the output register once all axes are done and it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_data_r  <= out_data_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (locate_go) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/ngcl_checker.sv]
// Port-level checks on the locator, bound to the top level
`include "nonuniform_grid_cell_locator_core_assert.svh"

module ngcl_checker
  import ngcl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tuser,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  logic in_fire;
  logic locate_fire;
  logic load_fire;
  logic out_stall;

  assign in_fire     = in_tvalid && in_tready;
  assign locate_fire = in_fire && (in_tuser == REQ_LOCATE);
  assign load_fire   = in_fire && (in_tuser == REQ_LOAD);
  assign out_stall   = out_tvalid && !out_tready;

  // A stalled result keeps its value
  `NGCL_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "result moved")

  // A locate closes the input for its walk
  `NGCL_ASSERT_NEXT(a_locate_busy, locate_fire, !in_tready, "input open in walk")

  // A load never yields a result
  `NGCL_ASSERT_NEXT(a_load_silent, load_fire && !out_tvalid, !out_tvalid, "result after a load")

  // A walk needs several memory reads before a result exists
  `NGCL_ASSERT_NEXT(a_locate_latency, locate_fire && !out_tvalid, !out_tvalid, "result too early")

  // Padding bits of the result stay zero
  `NGCL_ASSERT_SAME(a_out_pad, out_tvalid, out_tdata[OUT_TDATA_W-1:25] == '0, "padding not zero")

endmodule

bind nonuniform_grid_cell_locator_core ngcl_checker u_ngcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[tb/nonuniform_grid_cell_locator_core_tb.sv]
// Self-checking testbench for the nonuniform grid cell locator core
module nonuniform_grid_cell_locator_core_tb;
  import ngcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Axis code that names no table: loads to it are dropped by the block
  localparam logic [1:0] AXIS_UNUSED = 2'd3;

  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

  localparam int RANDOM_ITEMS = 640;    // loads and locates in the random part
  localparam int PHASE_MARGIN = 16;     // idle margin after each phase
  localparam int TAIL_CYCLES  = 300;    // idle tail before the final check
  localparam int HOLD_CYCLES  = 600;    // long receiver back-pressure
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [1:0]             cfg_addr;
  logic [CNT_W-1:0]       cfg_wdata;

  // Tracks the vertex tables and cell counts as the block sees them, and
  // predicts the cell and box flag of every accepted locate item.
  class cell_locate_checker;
    // Field order matches out_tdata: cell_x in the lowest bits
    typedef struct packed {
      logic              in_box;
      logic [CELL_W-1:0] cell_z;
      logic [CELL_W-1:0] cell_y;
      logic [CELL_W-1:0] cell_x;
    } locate_res_t;

    int          vtx [3][TABLE_DEPTH];
    int unsigned n_cells [3];
    logic [2:0]  incl_mask;
    locate_res_t pending_cells [$];
    int          errors;
    int          reported;

    function new();
      n_cells   = '{1, 1, 1};
      incl_mask = '0;
      errors    = 0;
      reported  = 0;
    endfunction

    // Last slot of the walk: ghost offset plus cells, clipped to the table
    static function int unsigned walk_end(int unsigned c);
      int unsigned e;
      e = GHOST_CELLS + c;
      if (e > TABLE_DEPTH - 1) e = TABLE_DEPTH - 1;
      return e;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        CFG_CELLS_X:    n_cells[0] = val;
        CFG_CELLS_Y:    n_cells[1] = val;
        CFG_CELLS_Z:    n_cells[2] = val;
        CFG_RIGHT_EDGE: incl_mask  = val[2:0];
        default: ;
      endcase
    endfunction

    function locate_res_t predict_cells(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                        logic [COORD_W-1:0] pz);
      locate_res_t       res;
      logic [CELL_W-1:0] cellv [3];
      int                pt [3];
      int unsigned       e;
      int unsigned       i;
      bit                in_box_v;
      pt[0]    = px;
      pt[1]    = py;
      pt[2]    = pz;
      in_box_v = 1'b1;
      for (int d = 0; d < 3; d++) begin
        e = walk_end(n_cells[d]);
        i = GHOST_CELLS;
        // Step while the midpoint of slots i, i+1 lies strictly below the
        // coordinate; compare doubled values so nothing is rounded.
        forever begin
          if (longint'(vtx[d][i]) + longint'(vtx[d][i+1]) >= 2 * longint'(pt[d])) break;
          i++;
          if (i >= e) break;
        end
        cellv[d] = CELL_W'(i - 1);
        if (pt[d] < vtx[d][GHOST_CELLS]) in_box_v = 1'b0;
        if (incl_mask[d] ? (pt[d] > vtx[d][e]) : (pt[d] >= vtx[d][e])) in_box_v = 1'b0;
      end
      res.cell_x = cellv[0];
      res.cell_y = cellv[1];
      res.cell_z = cellv[2];
      res.in_box = in_box_v;
      return res;
    endfunction

    function void note_item(logic tuser, logic [IN_TDATA_W-1:0] td);
      logic [1:0]        ax;
      logic [ADDR_W-1:0] slot;
      ax   = td[IN_AXIS_LSB +: 2];
      slot = td[IN_SLOT_LSB +: ADDR_W];
      if (tuser == REQ_LOAD) begin
        if (ax != AXIS_UNUSED) vtx[ax][slot] = td[IN_COORD_LSB +: COORD_W];
      end else begin
        pending_cells.push_back(predict_cells(td[IN_PX_LSB +: COORD_W],
                                              td[IN_PY_LSB +: COORD_W],
                                              td[IN_PZ_LSB +: COORD_W]));
      end
    endfunction

    function void complain(string msg);
      errors++;
      if (reported < 10) begin
        reported++;
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td);
      locate_res_t got;
      locate_res_t want;
      got = locate_res_t'(td[3*CELL_W:0]);
      if (pending_cells.size() == 0) begin
        complain($sformatf("result with no locate pending: cells %0d/%0d/%0d in_box %0b",
                           got.cell_x, got.cell_y, got.cell_z, got.in_box));
        return;
      end
      want = pending_cells.pop_front();
      if (got.cell_x !== want.cell_x)
        complain($sformatf("cell_x expected %0d got %0d", want.cell_x, got.cell_x));
      if (got.cell_y !== want.cell_y)
        complain($sformatf("cell_y expected %0d got %0d", want.cell_y, got.cell_y));
      if (got.cell_z !== want.cell_z)
        complain($sformatf("cell_z expected %0d got %0d", want.cell_z, got.cell_z));
      if (got.in_box !== want.in_box)
        complain($sformatf("in_box expected %0b got %0b", want.in_box, got.in_box));
    endfunction

    function void finish_check();
      if (pending_cells.size() != 0)
        complain($sformatf("%0d locate results never arrived", pending_cells.size()));
    endfunction
  endclass

  cell_locate_checker sb;

  // Stimulus-side copy of the tables and cell counts, updated as items are
  // issued, so new points can be aimed at cells and bounds.
  int          gtab [3][TABLE_DEPTH];
  int unsigned gcells [3];

  bit src_gaps;
  bit sink_gaps;
  bit hold_req;

  nonuniform_grid_cell_locator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick one coordinate for a locate on axis d: inside a cell, on a box
  // bound, on a vertex, around a midpoint, just outside the box, or anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(int d);
    int unsigned e;
    int unsigned k;
    longint      a;
    longint      b;
    longint      t;
    int          r;
    e = cell_locate_checker::walk_end(gcells[d]);
    r = $urandom_range(0, 99);
    k = $urandom_range(GHOST_CELLS, e);
    a = gtab[d][k];
    b = (k < TABLE_DEPTH - 1) ? gtab[d][k+1] : a;
    if (b < a) begin
      t = a;
      a = b;
      b = t;
    end
    if (r < 45) return COORD_W'(a + longint'($urandom_range(0, 32'(b - a))));
    if (r < 55) return gtab[d][(r & 1) ? GHOST_CELLS : e];
    if (r < 62) return COORD_W'(a);
    if (r < 77) begin
      t = (a + b) >>> 1;
      return COORD_W'(t + longint'($urandom_range(0, 2)) - 1);
    end
    if (r < 87) begin
      if (r & 1) return COORD_W'(longint'(gtab[d][GHOST_CELLS]) - 1 -
                                 longint'($urandom_range(0, 4095)));
      return COORD_W'(longint'(gtab[d][e]) + 1 + longint'($urandom_range(0, 4095)));
    end
    return $urandom;
  endfunction

  // Floor of the midpoint of slots k and k+1 on axis d
  function automatic logic [COORD_W-1:0] mid_of(int d, int k);
    longint m;
    m = (longint'(gtab[d][k]) + longint'(gtab[d][k+1])) >>> 1;
    return COORD_W'(m);
  endfunction

  // Upper box bound on axis d under the current cell count
  function automatic logic [COORD_W-1:0] hi_of(int d);
    return gtab[d][cell_locate_checker::walk_end(gcells[d])];
  endfunction

  // Offer one item and hold it until the block takes it. Keep tvalid high
  // across back-to-back items; drop it only for a gap.
  task automatic send_item(logic req, logic [1:0] ax, logic [7:0] slot,
                           logic [COORD_W-1:0] coord, logic [COORD_W-1:0] px,
                           logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
    logic [IN_TDATA_W-1:0] td;
    int                    g;
    td = '0;
    td[IN_AXIS_LSB  +: 2]       = ax;
    td[IN_SLOT_LSB  +: 8]       = slot;
    td[IN_COORD_LSB +: COORD_W] = coord;
    td[IN_PX_LSB    +: COORD_W] = px;
    td[IN_PY_LSB    +: COORD_W] = py;
    td[IN_PZ_LSB    +: COORD_W] = pz;
    g = src_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata  <= td;
    in_tuser  <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Load one vertex; fill the point fields with noise
  task automatic load_vertex(logic [1:0] ax, logic [7:0] slot, logic [COORD_W-1:0] coord);
    if (ax != AXIS_UNUSED) gtab[ax][slot] = coord;
    send_item(REQ_LOAD, ax, slot, coord, $urandom, $urandom, $urandom);
  endtask

  // Locate one point; fill the load fields with noise
  task automatic locate_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [COORD_W-1:0] pz);
    send_item(REQ_LOCATE, 2'($urandom_range(0, 3)), 8'($urandom), $urandom, px, py, pz);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Write all four registers back to back; only call while the block idles
  task automatic set_config(int unsigned cx, int unsigned cy, int unsigned cz,
                            logic [2:0] edge_mask);
    write_reg(CFG_CELLS_X, CNT_W'(cx));
    write_reg(CFG_CELLS_Y, CNT_W'(cy));
    write_reg(CFG_CELLS_Z, CNT_W'(cz));
    write_reg(CFG_RIGHT_EDGE, CNT_W'(edge_mask));
    cfg_we <= 1'b0;
    gcells = '{cx, cy, cz};
  endtask

  // Stop offering, let the last accept reach the scoreboard, wait for every
  // expected result, then let the tail pass
  task automatic settle(int margin);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
  endtask

  function automatic int unsigned extreme_cells();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return 251;
      default: return 255;
    endcase
  endfunction

  // Sample both handshakes on the clock edge; predict on accepted input,
  // compare on accepted output.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Receiver: random stalls, one long hold on request, stretches of none
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 99) < 30) begin
        out_tready <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          n_done;
    int          phase;
    int          n_phase;
    int          r;
    int          ax;
    int unsigned slot;
    longint      a;
    longint      b;
    longint      t;
    longint      v;

    sb        = new();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    hold_req  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= REQ_LOAD;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_CELLS_X;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot of every table with rising, unevenly spaced vertices
    // from the most negative to the most positive coordinate, so that no
    // locate ever reads an unwritten entry.
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      for (int d = 0; d < 3; d++) begin
        if (k == 0) v = longint'($signed(COORD_MIN));
        else if (k == TABLE_DEPTH - 1) v = longint'(COORD_MAX);
        else v = longint'(k) * 64'sd16777216 - 64'sd2147483648 +
                 longint'($urandom_range(0, 24'hff_ffff));
        load_vertex(2'(d), 8'(k), COORD_W'(v));
      end
    end
    settle(PHASE_MARGIN);

    // Directed: zero cells on x, one on y, walk end clipped to the last slot
    // on z; inclusive upper bound on x and z.
    set_config(0, 1, 255, 3'b101);
    locate_point(COORD_MIN, COORD_MIN, COORD_MIN);
    locate_point(COORD_MAX, COORD_MAX, COORD_MAX);
    locate_point('0, '0, '0);
    locate_point(gtab[0][GHOST_CELLS], gtab[1][GHOST_CELLS], gtab[2][GHOST_CELLS]);
    locate_point(hi_of(0), hi_of(1), hi_of(2));
    locate_point(hi_of(0) - 1, hi_of(1) - 1, hi_of(2) - 1);
    locate_point(mid_of(0, GHOST_CELLS), mid_of(1, GHOST_CELLS), mid_of(2, GHOST_CELLS));
    locate_point(mid_of(0, GHOST_CELLS) + 1, mid_of(1, GHOST_CELLS) + 1,
                 mid_of(2, GHOST_CELLS) + 1);
    load_vertex(AXIS_UNUSED, 8'h5a, 32'h1234_5678);   // must be dropped
    load_vertex(AXIS_X, 8'hff, COORD_MAX);
    load_vertex(AXIS_Y, 8'h00, COORD_MIN);
    load_vertex(AXIS_Z, 8'h80, gtab[2][128]);
    locate_point(gtab[0][GHOST_CELLS] - 1, gtab[1][GHOST_CELLS] - 1, gtab[2][GHOST_CELLS] - 1);
    settle(PHASE_MARGIN);

    // Directed: large cell counts on x and y, one on z, exclusive bounds except on y
    set_config(251, 251, 1, 3'b010);
    locate_point(hi_of(0), hi_of(1), hi_of(2));
    locate_point(mid_of(0, 252), mid_of(1, 252), mid_of(2, 252));
    locate_point(mid_of(0, 252) + 1, mid_of(1, 252) + 1, mid_of(2, 252) + 1);
    locate_point(COORD_MAX, COORD_MAX, COORD_MAX);
    locate_point(pick_coord(0), pick_coord(1), pick_coord(2));
    settle(PHASE_MARGIN);

    // Random phases: mostly small cell counts, a few large or extreme ones.
    // Phase one runs the long receiver hold with the sender at full rate.
    n_done = 0;
    phase  = 0;
    while (n_done < RANDOM_ITEMS) begin
      r = (phase == 1) ? 5 : $urandom_range(0, 9);
      if (r == 0)
        set_config($urandom_range(200, 255), $urandom_range(200, 255),
                   $urandom_range(200, 255), 3'($urandom_range(0, 7)));
      else if (r == 1)
        set_config(extreme_cells(), extreme_cells(), extreme_cells(),
                   3'($urandom_range(0, 7)));
      else
        set_config($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                   3'($urandom_range(0, 7)));
      n_phase   = (r <= 1) ? 12 : 120;
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        src_gaps = 1'b0;
        hold_req = 1'b1;
      end

      for (int k = 0; k < n_phase; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // Rewrite one interior vertex, kept between its neighbors
          ax   = $urandom_range(0, 2);
          slot = $urandom_range(1, TABLE_DEPTH - 2);
          a    = gtab[ax][slot-1];
          b    = gtab[ax][slot+1];
          if (b < a) begin
            t = a;
            a = b;
            b = t;
          end
          load_vertex(2'(ax), 8'(slot),
                      COORD_W'(a + longint'($urandom_range(0, 32'(b - a)))));
          n_done++;
        end else if (r < 13) begin
          // Any slot, any value: may leave a table out of order
          load_vertex(2'($urandom_range(0, 2)), 8'($urandom), $urandom);
          n_done++;
        end else if (r < 15) begin
          load_vertex(AXIS_UNUSED, 8'($urandom), $urandom);
        end else begin
          locate_point(pick_coord(0), pick_coord(1), pick_coord(2));
          n_done++;
        end
      end
      settle(PHASE_MARGIN);
      phase++;
    end

    settle(TAIL_CYCLES);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ngcl_pkg.sv
rtl/ngcl_ram.sv
rtl/ngcl_axis_walk.sv
rtl/nonuniform_grid_cell_locator_core.sv
rtl/ngcl_checker.sv
tb/nonuniform_grid_cell_locator_core_tb.sv
